// ----- design/tsg_pkg.sv -----
// Shared types, symbol codes, register indexes and trig helpers for the turtle segment generator.
package tsg_pkg;

  // ASCII codes of the symbols that do something
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_LENGTH   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TURN_STEP     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_START_X       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_START_Y       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_START_HEADING = 3'd4;

  // Register reset values
  localparam logic [7:0]         STEP_LENGTH_RST   = 8'd20;
  localparam logic [8:0]         TURN_STEP_RST     = 9'd60;
  localparam logic signed [15:0] START_X_RST       = 16'sd200;
  localparam logic signed [15:0] START_Y_RST       = 16'sd100;
  localparam logic [8:0]         START_HEADING_RST = 9'd0;

  // Angles in degrees
  localparam logic [9:0] FULL_TURN    = 10'd360;
  localparam logic [9:0] HALF_TURN    = 10'd180;
  localparam logic [9:0] QUARTER_TURN = 10'd90;
  localparam logic [9:0] THREE_QUARTER_TURN = 10'd270;

  // Quarter-wave sine table, 0..90 degrees
  localparam int SIN_ENTRIES   = 91;
  localparam int TRIG_W        = 25;
  localparam int SERIES_TERMS  = 40;
  localparam longint unsigned DEG_Q62 = 64'd80489105089764729;
  localparam longint unsigned ONE_Q62 = 64'h4000_0000_0000_0000;

  typedef logic [TRIG_W-1:0] trig_word_t;
  typedef trig_word_t sin_table_t [0:SIN_ENTRIES-1];

  // Decoded symbol
  typedef enum logic [1:0] {
    OP_NONE,
    OP_DRAW,
    OP_LEFT,
    OP_RIGHT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic restart;
  } item_t;

  typedef struct packed {
    logic [6:0] idx;
    logic       neg;
  } trig_sel_t;

  // Fold a value below 720 into 0..359
  function automatic logic [8:0] wrap360(input logic [9:0] d);
    logic [9:0] r;
    r = (d >= FULL_TURN) ? d - FULL_TURN : d;
    return r[8:0];
  endfunction

  // Table index and sign for sin of an angle below 450 degrees
  function automatic trig_sel_t trig_select(input logic [9:0] d);
    logic [9:0] r;
    logic [1:0] q;
    trig_sel_t  s;
    if (d < QUARTER_TURN) begin
      q = 2'd0;
      r = d;
    end else if (d < HALF_TURN) begin
      q = 2'd1;
      r = d - QUARTER_TURN;
    end else if (d < THREE_QUARTER_TURN) begin
      q = 2'd2;
      r = d - HALF_TURN;
    end else if (d < FULL_TURN) begin
      q = 2'd3;
      r = d - THREE_QUARTER_TURN;
    end else begin
      q = 2'd0;
      r = d - FULL_TURN;
    end
    s.idx = q[0] ? 7'(QUARTER_TURN - r) : 7'(r);
    s.neg = q[1];
    return s;
  endfunction

  // Elaboration-time sine table: Taylor series in unsigned Q2.62, rounded half up
  function automatic sin_table_t build_sin_table(input int frac);
    sin_table_t        tab;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint unsigned   sum;
    logic [127:0]      p;
    int                n;
    for (int k = 0; k < SIN_ENTRIES; k++) begin
      x    = DEG_Q62 * 64'(k);
      p    = {64'd0, x} * {64'd0, x};
      x2   = p[125:62];
      term = x;
      sum  = x;
      for (n = 1; n < SERIES_TERMS && term != 0; n++) begin
        p    = {64'd0, term} * {64'd0, x2};
        term = p[125:62] / 64'((2 * n) * (2 * n + 1));
        if (n[0]) sum = sum - term;
        else      sum = sum + term;
      end
      if (k == SIN_ENTRIES - 1 && sum > ONE_Q62) sum = ONE_Q62;
      sum    = (sum + (64'd1 << (61 - frac))) >> (62 - frac);
      tab[k] = TRIG_W'(sum);
    end
    return tab;
  endfunction

endpackage

// ----- design/tsg_sym_if.sv -----
// Input channel: one L-system symbol per item.
interface tsg_sym_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       restart;

  modport source (output valid, symbol, restart, input ready);
  modport sink (input valid, symbol, restart, output ready);
endinterface

// ----- design/tsg_seg_if.sv -----
// Output channel: one segment report per item.
interface tsg_seg_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic                          draw_line;
  logic signed [COORD_WIDTH-1:0] from_x;
  logic signed [COORD_WIDTH-1:0] from_y;
  logic signed [COORD_WIDTH-1:0] to_x;
  logic signed [COORD_WIDTH-1:0] to_y;
  logic [8:0]                    heading_now;
  logic signed [COORD_WIDTH-1:0] box_min_x;
  logic signed [COORD_WIDTH-1:0] box_max_x;
  logic signed [COORD_WIDTH-1:0] box_min_y;
  logic signed [COORD_WIDTH-1:0] box_max_y;

  modport source (output valid, draw_line, from_x, from_y, to_x, to_y, heading_now,
                  box_min_x, box_max_x, box_min_y, box_max_y, input ready);
  modport sink (input valid, draw_line, from_x, from_y, to_x, to_y, heading_now,
                box_min_x, box_max_x, box_min_y, box_max_y, output ready);
endinterface

// ----- design/tsg_cfg_if.sv -----
// Configuration write channel: register index and write data.
interface tsg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [15:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ----- design/tsg_front.sv -----
// Front end: accepts symbols and decodes them into queue items.
module tsg_front
  import tsg_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  tsg_sym_if.sink sym,
  output logic  push,
  output item_t push_item,
  input  logic  push_ready
);

  logic  held;
  item_t held_item;
  op_t   op_dec;

  // Symbol decode
  always_comb begin
    unique case (sym.symbol) inside
      CH_A, CH_B: op_dec = OP_DRAW;
      CH_PLUS:    op_dec = OP_LEFT;
      CH_MINUS:   op_dec = OP_RIGHT;
      default:    op_dec = OP_NONE;
    endcase
  end

  assign sym.ready = !held || push_ready;
  assign push      = held;
  assign push_item = held_item;

  // Decoded item register
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (sym.valid && sym.ready) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
    if (sym.valid && sym.ready) begin
      held_item.op      <= op_dec;
      held_item.restart <= sym.restart;
    end
  end

endmodule

// ----- design/tsg_queue.sv -----
// Short item queue between the front end and the execution pipeline.
module tsg_queue
  import tsg_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  push_ready,
  output logic  pop_valid,
  output item_t pop_item,
  input  logic  pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  item_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push && push_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)     rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      if (do_push && !pop)      count <= count + 1'b1;
      else if (!do_push && pop) count <= count - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_item;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (do_push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count lost a push");

endmodule

// ----- design/tsg_back.sv -----
// Execution pipeline: heading and trig lookup, scaling, pen move, bounding box.
module tsg_back
  import tsg_pkg::*;
#(
  parameter int COORD_WIDTH    = 16,
  parameter int TRIG_FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  q_valid,
  input  item_t q_item,
  output logic  q_pop,
  tsg_cfg_if.sink cfg,
  tsg_seg_if.source seg
);

  localparam int CW = COORD_WIDTH;
  localparam int FB = TRIG_FRAC_BITS;
  localparam int PW = FB + 9;
  localparam sin_table_t SIN_TAB = build_sin_table(FB);
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  // Saturate a 16-bit start coordinate into the coordinate range
  function automatic logic signed [CW-1:0] fit_coord(input logic signed [15:0] v);
    logic signed [32:0] w;
    w = 33'(v);
    if (w > 33'(CMAX)) w = 33'(CMAX);
    if (w < 33'(CMIN)) w = 33'(CMIN);
    return w[CW-1:0];
  endfunction

  // Clamp a one-bit-wider sum
  function automatic logic signed [CW-1:0] sat_sum(input logic signed [CW:0] s);
    if (s[CW] != s[CW-1]) return s[CW] ? CMIN : CMAX;
    return s[CW-1:0];
  endfunction

  // Configuration registers
  logic [7:0]         step_length;
  logic [8:0]         turn_step;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic [8:0]         start_heading;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_length   <= STEP_LENGTH_RST;
      turn_step     <= TURN_STEP_RST;
      start_x       <= START_X_RST;
      start_y       <= START_Y_RST;
      start_heading <= START_HEADING_RST;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        REG_STEP_LENGTH:   step_length   <= cfg.wdata[7:0];
        REG_TURN_STEP:     turn_step     <= cfg.wdata[8:0];
        REG_START_X:       start_x       <= cfg.wdata;
        REG_START_Y:       start_y       <= cfg.wdata;
        REG_START_HEADING: start_heading <= cfg.wdata[8:0];
        default: ;
      endcase
    end
  end

  logic [8:0]             turn_mod;
  logic [8:0]             head_start;
  logic signed [CW-1:0]   start_x_c;
  logic signed [CW-1:0]   start_y_c;

  assign turn_mod   = wrap360({1'b0, turn_step});
  assign head_start = wrap360({1'b0, start_heading});
  assign start_x_c  = fit_coord(start_x);
  assign start_y_c  = fit_coord(start_y);

  // Whole pipeline moves when the output register can take a result
  logic en;
  assign en    = !seg.valid || seg.ready;
  assign q_pop = en && q_valid;

  // Stage 1: heading update and table lookup
  logic [8:0] heading;
  logic [8:0] h_base;
  logic [8:0] h_next;
  trig_sel_t  cos_sel;
  trig_sel_t  sin_sel;

  assign h_base  = q_item.restart ? head_start : heading;
  assign cos_sel = trig_select({1'b0, h_base} + QUARTER_TURN);
  assign sin_sel = trig_select({1'b0, h_base});

  always_comb begin
    unique case (q_item.op)
      OP_LEFT:  h_next = wrap360({1'b0, h_base} + {1'b0, turn_mod});
      OP_RIGHT: h_next = wrap360({1'b0, h_base} + FULL_TURN - {1'b0, turn_mod});
      default:  h_next = h_base;
    endcase
  end

  logic          s1_valid;
  logic          s1_draw;
  logic          s1_restart;
  logic [8:0]    s1_heading;
  logic [FB:0]   s1_cmag;
  logic          s1_cneg;
  logic [FB:0]   s1_smag;
  logic          s1_sneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      heading  <= wrap360({1'b0, START_HEADING_RST});
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= q_valid;
      if (q_valid) heading <= h_next;
    end
    if (en) begin
      s1_draw    <= (q_item.op == OP_DRAW);
      s1_restart <= q_item.restart;
      s1_heading <= h_next;
      s1_cmag    <= SIN_TAB[cos_sel.idx][FB:0];
      s1_cneg    <= cos_sel.neg;
      s1_smag    <= SIN_TAB[sin_sel.idx][FB:0];
      s1_sneg    <= sin_sel.neg;
    end
  end

  // Stage 2: scale by step length, truncate toward zero
  logic [PW-1:0]     cprod;
  logic [PW-1:0]     sprod;
  logic [7:0]        cstep;
  logic [7:0]        sstep;
  logic signed [8:0] dx;
  logic signed [8:0] dy;

  assign cprod = PW'(s1_cmag) * PW'(step_length);
  assign sprod = PW'(s1_smag) * PW'(step_length);
  assign cstep = cprod[FB+7:FB];
  assign sstep = sprod[FB+7:FB];
  assign dx    = s1_cneg ? -$signed({1'b0, cstep}) : $signed({1'b0, cstep});
  assign dy    = s1_sneg ? -$signed({1'b0, sstep}) : $signed({1'b0, sstep});

  logic              s2_valid;
  logic              s2_draw;
  logic              s2_restart;
  logic [8:0]        s2_heading;
  logic signed [8:0] s2_dx;
  logic signed [8:0] s2_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
    if (en) begin
      s2_draw    <= s1_draw;
      s2_restart <= s1_restart;
      s2_heading <= s1_heading;
      s2_dx      <= dx;
      s2_dy      <= dy;
    end
  end

  // Stage 3: pen move with saturation
  logic signed [CW-1:0] pen_x;
  logic signed [CW-1:0] pen_y;
  logic signed [CW-1:0] fx;
  logic signed [CW-1:0] fy;
  logic signed [CW:0]   sum_x;
  logic signed [CW:0]   sum_y;
  logic signed [CW-1:0] tx;
  logic signed [CW-1:0] ty;

  assign fx    = s2_restart ? start_x_c : pen_x;
  assign fy    = s2_restart ? start_y_c : pen_y;
  assign sum_x = {fx[CW-1], fx} + (CW+1)'(s2_dx);
  assign sum_y = {fy[CW-1], fy} - (CW+1)'(s2_dy);
  assign tx    = s2_draw ? sat_sum(sum_x) : fx;
  assign ty    = s2_draw ? sat_sum(sum_y) : fy;

  logic                 s3_valid;
  logic                 s3_draw;
  logic                 s3_restart;
  logic [8:0]           s3_heading;
  logic signed [CW-1:0] s3_from_x;
  logic signed [CW-1:0] s3_from_y;
  logic signed [CW-1:0] s3_to_x;
  logic signed [CW-1:0] s3_to_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x    <= fit_coord(START_X_RST);
      pen_y    <= fit_coord(START_Y_RST);
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
      if (s2_valid) begin
        pen_x <= tx;
        pen_y <= ty;
      end
    end
    if (en) begin
      s3_draw    <= s2_draw;
      s3_restart <= s2_restart;
      s3_heading <= s2_heading;
      s3_from_x  <= fx;
      s3_from_y  <= fy;
      s3_to_x    <= tx;
      s3_to_y    <= ty;
    end
  end

  // Stage 4: bounding box and output register
  logic signed [CW-1:0] low_x;
  logic signed [CW-1:0] high_x;
  logic signed [CW-1:0] low_y;
  logic signed [CW-1:0] high_y;
  logic signed [CW-1:0] base_lx;
  logic signed [CW-1:0] base_hx;
  logic signed [CW-1:0] base_ly;
  logic signed [CW-1:0] base_hy;
  logic signed [CW-1:0] new_lx;
  logic signed [CW-1:0] new_hx;
  logic signed [CW-1:0] new_ly;
  logic signed [CW-1:0] new_hy;

  assign base_lx = s3_restart ? CMAX : low_x;
  assign base_hx = s3_restart ? CMIN : high_x;
  assign base_ly = s3_restart ? CMAX : low_y;
  assign base_hy = s3_restart ? CMIN : high_y;
  assign new_lx  = (s3_draw && s3_to_x < base_lx) ? s3_to_x : base_lx;
  assign new_hx  = (s3_draw && s3_to_x > base_hx) ? s3_to_x : base_hx;
  assign new_ly  = (s3_draw && s3_to_y < base_ly) ? s3_to_y : base_ly;
  assign new_hy  = (s3_draw && s3_to_y > base_hy) ? s3_to_y : base_hy;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_x     <= CMAX;
      high_x    <= CMIN;
      low_y     <= CMAX;
      high_y    <= CMIN;
      seg.valid <= 1'b0;
    end else if (en) begin
      seg.valid <= s3_valid;
      if (s3_valid) begin
        low_x  <= new_lx;
        high_x <= new_hx;
        low_y  <= new_ly;
        high_y <= new_hy;
      end
    end
    if (en) begin
      seg.draw_line   <= s3_draw;
      seg.from_x      <= s3_from_x;
      seg.from_y      <= s3_from_y;
      seg.to_x        <= s3_to_x;
      seg.to_y        <= s3_to_y;
      seg.heading_now <= s3_heading;
      seg.box_min_x   <= new_lx;
      seg.box_max_x   <= new_hx;
      seg.box_min_y   <= new_ly;
      seg.box_max_y   <= new_hy;
    end
  end

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    heading < FULL_TURN[8:0] && s1_heading < FULL_TURN[8:0] || !s1_valid && heading < 9'(FULL_TURN))
    else $error("heading out of range");

  a_nodraw_still: assert property (@(posedge clk) disable iff (rst)
    seg.valid && !seg.draw_line |-> seg.from_x == seg.to_x && seg.from_y == seg.to_y)
    else $error("pen moved on a non-drawing item");

  a_box_covers_end: assert property (@(posedge clk) disable iff (rst)
    seg.valid && seg.draw_line |->
      seg.box_min_x <= seg.to_x && seg.to_x <= seg.box_max_x &&
      seg.box_min_y <= seg.to_y && seg.to_y <= seg.box_max_y)
    else $error("bounding box misses segment end");

endmodule

// ----- design/turtle_segment_generator.sv -----
// A symbol passes the front-end register, the queue and the stage 1 to 4 registers.
// One item per cycle unless the output stalls; the pose registers each close a loop
// (heading add in stage 1, pen add in stage 3, box compare in stage 4).
// Output stalls freeze the pipeline; a 4-entry queue keeps the input side taking items.
// Synchronous reset loads the default registers, start pose and an empty bounding box.
module turtle_segment_generator
  import tsg_pkg::*;
#(
  parameter int COORD_WIDTH    = 16,
  parameter int TRIG_FRAC_BITS = 16
) (
  input logic clk,
  input logic rst,
  tsg_sym_if.sink   symbols,
  tsg_seg_if.source segments,
  tsg_cfg_if.sink   cfg
);

  logic  push;
  item_t push_item;
  logic  push_ready;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  tsg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .sym        (symbols),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  tsg_queue #(
    .DEPTH (4)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (q_pop)
  );

  tsg_back #(
    .COORD_WIDTH    (COORD_WIDTH),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .cfg     (cfg),
    .seg     (segments)
  );

endmodule

// ----- verif/tsg_tb_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard class that follows the turtle pose and checks each segment report.
package tsg_tb_pkg;
  import tsg_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_INDEX_LAST = 3'd7;
  localparam int COORD_MAX = 32767;
  localparam int COORD_MIN = -32768;
  localparam int DEGREES   = 360;
  localparam int QUARTER   = 90;
  localparam int FRAC_BITS = 16;
  localparam real FRAC_SCALE = 65536.0;
  localparam real PI = 3.14159265358979323846;

  typedef struct {
    logic               draw_line;
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
    logic [8:0]         heading_now;
    logic signed [15:0] box_min_x;
    logic signed [15:0] box_max_x;
    logic signed [15:0] box_min_y;
    logic signed [15:0] box_max_y;
  } segment_t;

  class pose_scoreboard;
    // register copies
    logic [7:0]         step_length;
    logic [8:0]         turn_step;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic [8:0]         start_heading;
    // pose and bounding box
    logic signed [15:0] pen_x;
    logic signed [15:0] pen_y;
    logic [8:0]         heading;
    logic signed [15:0] low_x;
    logic signed [15:0] high_x;
    logic signed [15:0] low_y;
    logic signed [15:0] high_y;
    // quarter-wave sine, Q1.16 rounded half up
    int                 sine_q16 [0:90];
    segment_t           expected_segs [$];
    int                 failures;

    function new();
      real rad;
      for (int k = 0; k <= QUARTER; k++) begin
        rad = k * PI / 180.0;
        sine_q16[k] = int'($floor($sin(rad) * FRAC_SCALE + 0.5));
      end
      step_length   = STEP_LENGTH_RST;
      turn_step     = TURN_STEP_RST;
      start_x       = START_X_RST;
      start_y       = START_Y_RST;
      start_heading = START_HEADING_RST;
      failures      = 0;
      load_start();
    endfunction

    function void load_start();
      pen_x   = start_x;
      pen_y   = start_y;
      heading = start_heading % DEGREES;
      low_x   = COORD_MAX;
      high_x  = COORD_MIN;
      low_y   = COORD_MAX;
      high_y  = COORD_MIN;
    endfunction

    function void apply_reg_write(logic [CFG_INDEX_W-1:0] idx, logic [15:0] data);
      case (idx)
        REG_STEP_LENGTH:   step_length = data[7:0];
        REG_TURN_STEP:     turn_step = data[8:0];
        REG_START_X:       start_x = data;
        REG_START_Y:       start_y = data;
        REG_START_HEADING: start_heading = data[8:0];
        default: ;
      endcase
    endfunction

    // sine of any non-negative angle from the quarter-wave table
    function int sin_deg(int d);
      int q;
      int r;
      int v;
      q = (d % DEGREES) / QUARTER;
      r = d % QUARTER;
      v = (q % 2 == 1) ? sine_q16[QUARTER - r] : sine_q16[r];
      return (q >= 2) ? -v : v;
    endfunction

    // length times Q1.16 value, truncated toward zero
    function int scaled_trunc(int len, int t);
      int p;
      p = len * t;
      if (p < 0) return -((-p) >>> FRAC_BITS);
      return p >>> FRAC_BITS;
    endfunction

    function logic signed [15:0] saturate(int v);
      if (v > COORD_MAX) return 16'(COORD_MAX);
      if (v < COORD_MIN) return 16'(COORD_MIN);
      return 16'(v);
    endfunction

    // advance the pose for one accepted symbol and queue the report it should give
    function void note_symbol(logic [7:0] sym, logic restart);
      segment_t s;
      int       dx;
      int       dy;
      int       turn;
      if (restart) load_start();
      s.from_x    = pen_x;
      s.from_y    = pen_y;
      s.draw_line = 1'b0;
      turn        = turn_step % DEGREES;
      if (sym == CH_A || sym == CH_B) begin
        dx = scaled_trunc(step_length, sin_deg(heading + QUARTER));
        dy = scaled_trunc(step_length, sin_deg(heading));
        pen_x = saturate(pen_x + dx);
        pen_y = saturate(pen_y - dy);
        if (pen_x < low_x) low_x = pen_x;
        if (pen_x > high_x) high_x = pen_x;
        if (pen_y < low_y) low_y = pen_y;
        if (pen_y > high_y) high_y = pen_y;
        s.draw_line = 1'b1;
      end else if (sym == CH_PLUS) begin
        heading = (heading + turn) % DEGREES;
      end else if (sym == CH_MINUS) begin
        heading = (heading + DEGREES - turn) % DEGREES;
      end
      s.to_x        = pen_x;
      s.to_y        = pen_y;
      s.heading_now = heading;
      s.box_min_x   = low_x;
      s.box_max_x   = high_x;
      s.box_min_y   = low_y;
      s.box_max_y   = high_y;
      expected_segs.push_back(s);
    endfunction

    function void check_field(string name, logic signed [16:0] want, logic signed [16:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_segment(segment_t got);
      segment_t want;
      if (expected_segs.size() == 0) begin
        $error("segment report with no symbol waiting");
        failures++;
        return;
      end
      want = expected_segs.pop_front();
      check_field("draw_line", want.draw_line, got.draw_line);
      check_field("from_x", want.from_x, got.from_x);
      check_field("from_y", want.from_y, got.from_y);
      check_field("to_x", want.to_x, got.to_x);
      check_field("to_y", want.to_y, got.to_y);
      check_field("heading_now", want.heading_now, got.heading_now);
      check_field("box_min_x", want.box_min_x, got.box_min_x);
      check_field("box_max_x", want.box_max_x, got.box_max_x);
      check_field("box_min_y", want.box_min_y, got.box_min_y);
      check_field("box_max_y", want.box_max_y, got.box_max_y);
    endfunction

    function int pending();
      return expected_segs.size();
    endfunction
  endclass

endpackage

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Top-level testbench: drives symbols and register writes, checks segment reports.
module tb_top;
  import tsg_pkg::*;
  import tsg_tb_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int RST_CYCLES  = 9;
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_ITEMS = 155;
  localparam int DRAIN_LIMIT = 20000;
  localparam int TAIL_CYCLES = 20;
  localparam int TIMEOUT_NS  = 10_000_000;

  logic clk;
  logic rst;
  bit   quiet;          // no new idling starts on either side while set
  int   stall_left = 0;

  tsg_sym_if sym_if();
  tsg_seg_if #(.COORD_WIDTH(16)) seg_if();
  tsg_cfg_if cfg_if();

  pose_scoreboard sb;

  turtle_segment_generator #(
    .COORD_WIDTH(16),
    .TRIG_FRAC_BITS(16)
  ) dut (
    .clk(clk),
    .rst(rst),
    .symbols(sym_if),
    .segments(seg_if),
    .cfg(cfg_if)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // idle lengths: mostly short, a few long
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int sender_gap();
    if (quiet || $urandom_range(0, 99) < 65) return 0;
    return idle_len();
  endfunction

  // receiver back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      seg_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < 25) begin
      seg_if.ready <= 1'b0;
      stall_left <= idle_len() - 1;
    end else begin
      seg_if.ready <= 1'b1;
    end
  end

  // monitor: every handshake goes to the scoreboard
  always @(posedge clk) begin
    segment_t got;
    if (!rst) begin
      if (seg_if.valid && seg_if.ready) begin
        got.draw_line   = seg_if.draw_line;
        got.from_x      = seg_if.from_x;
        got.from_y      = seg_if.from_y;
        got.to_x        = seg_if.to_x;
        got.to_y        = seg_if.to_y;
        got.heading_now = seg_if.heading_now;
        got.box_min_x   = seg_if.box_min_x;
        got.box_max_x   = seg_if.box_max_x;
        got.box_min_y   = seg_if.box_min_y;
        got.box_max_y   = seg_if.box_max_y;
        sb.check_segment(got);
      end
      if (sym_if.valid && sym_if.ready) sb.note_symbol(sym_if.symbol, sym_if.restart);
      if (cfg_if.valid && cfg_if.ready) sb.apply_reg_write(cfg_if.reg_index, cfg_if.wdata);
    end
  end

  // one symbol item; valid stays high afterward unless the next call idles
  task automatic send_symbol(logic [7:0] sym, logic restart);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      sym_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sym_if.valid   <= 1'b1;
    sym_if.symbol  <= sym;
    sym_if.restart <= restart;
    @(posedge clk);
    while (!sym_if.ready) @(posedge clk);
  endtask

  // wait until every queued report has come back
  task automatic wait_results();
    int spins;
    spins = 0;
    @(posedge clk);
    while (sb.pending() != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    if (sb.pending() != 0) begin
      $error("%0d segment reports never arrived", sb.pending());
      sb.failures++;
      sb.expected_segs.delete();
    end
  endtask

  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [15:0] data);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  // stop the symbol stream, let the block go idle, then write every register
  task automatic reconfigure(int step_len, int turn, int sx, int sy, int sh);
    sym_if.valid <= 1'b0;
    wait_results();
    cfg_write(REG_STEP_LENGTH, {8'($urandom), 8'(step_len)});
    cfg_write(REG_TURN_STEP, {7'($urandom), 9'(turn)});
    cfg_write(REG_START_X, 16'(sx));
    cfg_write(REG_START_Y, 16'(sy));
    cfg_write(REG_START_HEADING, {7'($urandom), 9'(sh)});
    if ($urandom_range(0, 2) == 0)
      cfg_write(3'($urandom_range(REG_INDEX_LAST, REG_START_HEADING + 1)), 16'($urandom));
    cfg_if.valid <= 1'b0;
  endtask

  function automatic int pick_step();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 255;
      2, 3: return $urandom_range(1, 30);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic int pick_turn();
    case ($urandom_range(0, 7))
      0: return 90;
      1: return 60;
      2: return 45;
      3: return 120;
      4: return 25;
      5: return $urandom_range(355, 511);
      default: return $urandom_range(0, 511);
    endcase
  endfunction

  function automatic int pick_start();
    case ($urandom_range(0, 3))
      0: return COORD_MAX - int'($urandom_range(0, 700));
      1: return COORD_MIN + int'($urandom_range(0, 700));
      2: return int'($urandom_range(0, 1000)) - 500;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // mostly drawing and turning symbols, some noise bytes
  task automatic send_random_symbol(logic restart);
    int r;
    r = $urandom_range(0, 99);
    if (r < 40)      send_symbol(CH_A, restart);
    else if (r < 55) send_symbol(CH_B, restart);
    else if (r < 70) send_symbol(CH_PLUS, restart);
    else if (r < 85) send_symbol(CH_MINUS, restart);
    else             send_symbol(8'($urandom), restart);
  endtask

  // stimulus
  initial begin
    sb = new();
    rst              <= 1'b1;
    quiet            = 1'b0;
    sym_if.valid     <= 1'b0;
    sym_if.symbol    <= '0;
    sym_if.restart   <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.reg_index <= '0;
    cfg_if.wdata     <= '0;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset pose, turns both ways, other symbols, restarts
    send_symbol(CH_A, 1'b0);
    send_symbol(CH_PLUS, 1'b0);
    send_symbol(CH_B, 1'b0);
    send_symbol(CH_MINUS, 1'b0);
    send_symbol(CH_MINUS, 1'b0);
    send_symbol(CH_A, 1'b0);
    send_symbol("F", 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hff, 1'b1);
    send_symbol(CH_A, 1'b1);

    // longest step from the corners: the end point saturates
    reconfigure(255, 90, COORD_MAX, COORD_MIN, 0);
    send_symbol(CH_A, 1'b1);
    send_symbol(CH_PLUS, 1'b0);
    send_symbol(CH_A, 1'b0);
    send_symbol(CH_MINUS, 1'b0);
    send_symbol(CH_MINUS, 1'b0);
    send_symbol(CH_B, 1'b0);

    // zero step, turn and start heading above a full turn
    reconfigure(0, 511, COORD_MIN, COORD_MAX, 511);
    send_symbol(CH_A, 1'b1);
    send_symbol(CH_PLUS, 1'b0);
    send_symbol(CH_B, 1'b0);
    send_symbol(CH_MINUS, 1'b0);

    // facing left from the low corner
    reconfigure(255, 359, COORD_MIN, COORD_MAX, 180);
    send_symbol(CH_A, 1'b1);
    send_symbol(CH_MINUS, 1'b0);
    send_symbol(CH_A, 1'b0);

    // random phases, each with its own register settings
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      reconfigure(pick_step(), pick_turn(), pick_start(), pick_start(),
                  $urandom_range(0, 511));
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // sender holds off until the pipeline is empty
        if (i == PHASE_ITEMS / 2 && (phase == 0 || $urandom_range(0, 2) == 0)) begin
          sym_if.valid <= 1'b0;
          wait_results();
        end
        send_random_symbol(i == 0 || $urandom_range(0, 99) < 3);
      end
      quiet = 1'b0;
    end

    sym_if.valid <= 1'b0;
    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL");
    $finish;
  end

endmodule
